FILE: rtl/zcfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package zcfm_pkg;

    // field widths
    localparam int SampleW  = 16;
    localparam int WinLenW  = 11;
    localparam int IndexW   = 10;
    localparam int CountW   = 10;
    localparam int CyclesW  = 9;
    localparam int SegW     = 8;
    localparam int PlaceW   = 2;
    localparam int DigitW   = 4;
    localparam int OutDataW = 24;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 16;

    // register reset values and window limits
    localparam logic [SampleW-1:0] ThresholdReset = 16'd19661;
    localparam logic [WinLenW-1:0] WinLenReset    = 11'd512;
    localparam logic [WinLenW-1:0] WinLenMax      = 11'd1024;
    localparam logic [WinLenW-1:0] WinLenMin      = 11'd1;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_WIN_LEN   = 1'd1;

    // digit place codes
    localparam logic [PlaceW-1:0] PLACE_HUNDREDS = 2'd0;
    localparam logic [PlaceW-1:0] PLACE_TENS     = 2'd1;
    localparam logic [PlaceW-1:0] PLACE_ONES     = 2'd2;

    localparam logic [SegW-1:0] SegDecimalPoint = 8'h80;

    // finished window handed to the display stage
    typedef struct packed {
        logic               valid;
        logic [CyclesW-1:0] cycles;
    } zcfm_win_t;

    // seven-segment pattern of one decimal digit
    function automatic logic [SegW-1:0] seg_code(input logic [DigitW-1:0] digit);
        logic [SegW-1:0] code;
        unique case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/zcfm_digit_out.sv
`timescale 1ns / 1ps
`default_nettype none

module zcfm_digit_out (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire zcfm_pkg::zcfm_win_t             win,
    output logic                                 take,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // segments [7:0], digit_place [9:8], cycles [18:10], zero [23:19]
    output logic [zcfm_pkg::OutDataW-1:0]        m_tdata,
    output logic                                 m_tlast
);
    import zcfm_pkg::*;

    logic                 act_valid_reg, act_valid_next;
    logic [PlaceW-1:0]    place_reg, place_next;
    logic [CyclesW-1:0]   cycles_reg, cycles_next;
    logic [DigitW-1:0]    hund_reg, hund_next;
    logic [DigitW-1:0]    tens_reg, tens_next;
    logic [DigitW-1:0]    ones_reg, ones_next;

    logic                 xfer;
    logic                 done_last;
    logic [14:0]          hund_prod;
    logic [2:0]           hund_dig;
    logic [CyclesW-1:0]   hund_rem;
    logic [14:0]          tens_prod;
    logic [DigitW-1:0]    tens_dig;
    logic [6:0]           tens_rem;
    logic [6:0]           ones_wide;
    logic [DigitW-1:0]    cur_digit;
    logic [SegW-1:0]      seg;

    // decimal split by reciprocal multiplies, exact for values below 512
    always_comb
    begin
        hund_prod = 15'(win.cycles) * 15'd41;
        hund_dig  = hund_prod[14:12];
        hund_rem  = win.cycles - CyclesW'(hund_dig) * CyclesW'(100);
        tens_rem  = hund_rem[6:0];
        tens_prod = 15'(tens_rem) * 15'd205;
        tens_dig  = tens_prod[14:11];
        ones_wide = tens_rem - 7'(tens_dig) * 7'd10;
    end

    assign xfer      = act_valid_reg && m_tready;
    assign done_last = xfer && (place_reg == PLACE_ONES);
    assign take      = win.valid && (!act_valid_reg || done_last);

    // sequencing of the three digit transfers
    always_comb
    begin
        act_valid_next = act_valid_reg;
        place_next     = place_reg;
        cycles_next    = cycles_reg;
        hund_next      = hund_reg;
        tens_next      = tens_reg;
        ones_next      = ones_reg;
        if (take)
        begin
            act_valid_next = 1'b1;
            place_next     = PLACE_HUNDREDS;
            cycles_next    = win.cycles;
            hund_next      = DigitW'(hund_dig);
            tens_next      = tens_dig;
            ones_next      = ones_wide[DigitW-1:0];
        end
        else if (done_last)
        begin
            act_valid_next = 1'b0;
        end
        else if (xfer)
        begin
            place_next = place_reg + PlaceW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_valid_reg <= 1'b0;
            place_reg     <= PLACE_HUNDREDS;
        end
        else
        begin
            act_valid_reg <= act_valid_next;
            place_reg     <= place_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cycles_reg <= cycles_next;
        hund_reg   <= hund_next;
        tens_reg   <= tens_next;
        ones_reg   <= ones_next;
    end

    // pattern for the digit on show
    always_comb
    begin
        unique case (place_reg)
            PLACE_HUNDREDS: cur_digit = hund_reg;
            PLACE_TENS:     cur_digit = tens_reg;
            PLACE_ONES:     cur_digit = ones_reg;
            default:        cur_digit = ones_reg;
        endcase
        seg = seg_code(cur_digit);
        if (place_reg == PLACE_ONES)
        begin
            seg = seg | SegDecimalPoint;
        end
    end

    assign m_tvalid = act_valid_reg;
    assign m_tlast  = (place_reg == PLACE_ONES);
    assign m_tdata  = {5'd0, cycles_reg, place_reg, seg};

    // a loaded window starts on the hundreds digit
    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (act_valid_reg && place_reg == PLACE_HUNDREDS))
        else $error("loaded window does not start on hundreds");

    // digits on show are decimal
    a_digits_dec: assert property (@(posedge clk) disable iff (!rst_n)
        act_valid_reg |-> (hund_reg < 4'd10 && tens_reg < 4'd10 && ones_reg < 4'd10))
        else $error("digit out of decimal range");

    // place never goes past ones while active
    a_place_range: assert property (@(posedge clk) disable iff (!rst_n)
        act_valid_reg |-> (place_reg == PLACE_HUNDREDS || place_reg == PLACE_TENS ||
                           place_reg == PLACE_ONES))
        else $error("digit place out of range");

endmodule

`default_nettype wire

FILE: rtl/zero_crossing_frequency_meter.sv
`timescale 1ns / 1ps
`default_nettype none

// Zero-crossing frequency meter. Takes one 16-bit unsigned sample per clock
// on the s_ side while s_tready is high and counts threshold crossings over
// windows of window_length samples (low 11 bits kept; 0 and 1 act as 1,
// above 1024 acts as 1024). At the end of each window it sends three
// transfers on the m_ side, one per cycle while m_tready is high: hundreds,
// tens and ones seven-segment codes of half the crossing count, the ones
// code with its decimal point and tlast set. A finished window waits in a
// one-entry holding register while the previous one is shown; s_tready
// drops only when that register is full and is not handed to the digit
// output in the same cycle, so with m_tready high, windows of three or more
// samples run at one sample per cycle; shorter ones wait on digit output.
// Write threshold and window_length only while the block is idle.
module zero_crossing_frequency_meter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [zcfm_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [zcfm_pkg::CfgDataW-1:0] cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // sample [15:0]
    input  wire logic [zcfm_pkg::SampleW-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // segments [7:0], digit_place [9:8], cycles [18:10], zero [23:19]
    output logic [zcfm_pkg::OutDataW-1:0]      m_tdata,
    output logic                               m_tlast
);
    import zcfm_pkg::*;

    logic [SampleW-1:0]  threshold_reg;
    logic [WinLenW-1:0]  win_len_reg;
    logic                level_reg, level_next;
    logic [CountW-1:0]   count_reg, count_next;
    logic [IndexW-1:0]   index_reg, index_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [CyclesW-1:0]  pend_cycles_reg, pend_cycles_next;

    logic                accept;
    logic                above, below;
    logic [WinLenW-1:0]  eff_len;
    logic [WinLenW-1:0]  index_inc;
    logic                win_end;
    logic                take;
    logic                lvl_upd;
    logic [CountW-1:0]   cnt_upd;
    zcfm_win_t           win;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= ThresholdReset;
            win_len_reg   <= WinLenReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data;
                REG_WIN_LEN:   win_len_reg   <= cfg_data[WinLenW-1:0];
                default:       ;
            endcase
        end
    end

    assign accept = s_tvalid && s_tready;
    assign above  = s_tdata > threshold_reg;
    assign below  = s_tdata < threshold_reg;

    // clamped window length and end of window
    always_comb
    begin
        eff_len = win_len_reg;
        if (win_len_reg < WinLenMin)
        begin
            eff_len = WinLenMin;
        end
        else if (win_len_reg > WinLenMax)
        begin
            eff_len = WinLenMax;
        end
        index_inc = WinLenW'(index_reg) + WinLenW'(1);
        win_end   = index_inc >= eff_len;
    end

    // level flag and crossing count for this sample
    always_comb
    begin
        lvl_upd = level_reg;
        cnt_upd = count_reg;
        priority if (index_reg == '0)
        begin
            lvl_upd = above;
            cnt_upd = '0;
        end
        else if (level_reg && below)
        begin
            lvl_upd = 1'b0;
            cnt_upd = count_reg + CountW'(1);
        end
        else if (!level_reg && above)
        begin
            lvl_upd = 1'b1;
            cnt_upd = count_reg + CountW'(1);
        end
    end

    // window state and holding register
    always_comb
    begin
        level_next       = level_reg;
        count_next       = count_reg;
        index_next       = index_reg;
        pend_valid_next  = pend_valid_reg && !take;
        pend_cycles_next = pend_cycles_reg;
        if (accept)
        begin
            level_next = lvl_upd;
            if (win_end)
            begin
                count_next       = '0;
                index_next       = '0;
                pend_valid_next  = 1'b1;
                pend_cycles_next = cnt_upd[CountW-1:1];
            end
            else
            begin
                count_next = cnt_upd;
                index_next = index_inc[IndexW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= 1'b0;
            count_reg      <= '0;
            index_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg      <= level_next;
            count_reg      <= count_next;
            index_reg      <= index_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_cycles_reg <= pend_cycles_next;
    end

    // holding register frees up in the cycle its window is taken
    assign s_tready   = !pend_valid_reg || take;
    assign win.valid  = pend_valid_reg;
    assign win.cycles = pend_cycles_reg;

    zcfm_digit_out u_digit_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .win      (win),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // a window end always leaves a finished window waiting
    a_win_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && win_end) |=> pend_valid_reg)
        else $error("window end lost");

    // at most one crossing per sample
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= index_reg)
        else $error("crossing count exceeds sample index");

    // state holds without a transfer
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(index_reg) && $stable(count_reg) && $stable(level_reg)))
        else $error("window state moved without a transfer");

endmodule

`default_nettype wire

FILE: tb/zcfm_checker.sv
`timescale 1ns / 1ps

module zcfm_checker
    import zcfm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic [SampleW-1:0]  s_tdata,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [OutDataW-1:0] m_tdata,
    input  wire logic                m_tlast,
    output int                       fail_count,
    output int                       pending
);

    // one displayed digit as it should leave the block
    typedef struct packed {
        logic [SegW-1:0]    segments;
        logic [PlaceW-1:0]  place;
        logic [CyclesW-1:0] cycles;
        logic               last;
    } digit_t;

    localparam logic [SegW-1:0] DIGIT_SEG [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    digit_t expected_digits[$];

    // shadow of the registers and the window state
    logic [SampleW-1:0] threshold;
    logic [WinLenW-1:0] win_len;
    logic               level_high;
    logic [CountW-1:0]  crossings;
    logic [IndexW-1:0]  position;

    task automatic queue_digit(input logic [SegW-1:0] seg, input logic [PlaceW-1:0] place,
                               input logic [CyclesW-1:0] cyc, input logic last);
        digit_t d;
        d.segments = seg;
        d.place    = place;
        d.cycles   = cyc;
        d.last     = last;
        expected_digits.push_back(d);
    endtask

    // level tracking and crossing count for one sample, digits at window end
    task automatic measure_sample(input logic [SampleW-1:0] s);
        logic [WinLenW-1:0] span;
        logic [CyclesW-1:0] cyc;
        int                 hundreds;
        int                 tens;
        int                 ones;
        if (position == '0)
        begin
            level_high = (s > threshold);
            crossings  = '0;
        end
        else if (level_high && s < threshold)
        begin
            level_high = 1'b0;
            crossings  = crossings + 1'b1;
        end
        else if (!level_high && s > threshold)
        begin
            level_high = 1'b1;
            crossings  = crossings + 1'b1;
        end

        span = win_len;
        if (span < WinLenMin)
            span = WinLenMin;
        if (span > WinLenMax)
            span = WinLenMax;

        if ({1'b0, position} + 11'd1 < span)
        begin
            position = position + 1'b1;
        end
        else
        begin
            cyc      = crossings[CountW-1:1];
            hundreds = (int'(cyc) / 100) % 10;
            tens     = (int'(cyc) / 10) % 10;
            ones     = int'(cyc) % 10;
            queue_digit(DIGIT_SEG[hundreds], PLACE_HUNDREDS, cyc, 1'b0);
            queue_digit(DIGIT_SEG[tens], PLACE_TENS, cyc, 1'b0);
            queue_digit(DIGIT_SEG[ones] | SegDecimalPoint, PLACE_ONES, cyc, 1'b1);
            position  = '0;
            crossings = '0;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // compare one output transfer with the oldest expected digit
    task automatic check_digit();
        digit_t want;
        if (expected_digits.size() == 0)
        begin
            $error("unexpected transfer: tdata %h, tlast %b", m_tdata, m_tlast);
            fail_count++;
        end
        else
        begin
            want = expected_digits.pop_front();
            check_field("segments", want.segments, m_tdata[7:0]);
            check_field("digit_place", want.place, m_tdata[9:8]);
            check_field("cycles", want.cycles, m_tdata[18:10]);
            check_field("zero", 0, m_tdata[23:19]);
            check_field("last", want.last, m_tlast);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold  = ThresholdReset;
            win_len    = WinLenReset;
            level_high = 1'b0;
            crossings  = '0;
            position   = '0;
            expected_digits.delete();
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_digit();
            if (cfg_we)
            begin
                if (cfg_index == REG_THRESHOLD)
                    threshold = cfg_data;
                else if (cfg_index == REG_WIN_LEN)
                    win_len = cfg_data[WinLenW-1:0];
            end
            if (s_tvalid && s_tready)
                measure_sample(s_tdata);
        end
        pending = expected_digits.size();
    end

endmodule

FILE: tb/zero_crossing_frequency_meter_tb.sv
`timescale 1ns / 1ps

module zero_crossing_frequency_meter_tb;
    import zcfm_pkg::*;

    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 370;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    logic                s_tvalid;
    wire                 s_tready;
    logic [SampleW-1:0]  s_tdata;
    wire                 m_tvalid;
    logic                m_tready;
    wire [OutDataW-1:0]  m_tdata;
    wire                 m_tlast;

    int fail_count;
    int pending;
    int stall_cycles;
    int tx_idle_pct;
    int rx_idle_pct;
    int random_sent;

    logic [SampleW-1:0] cur_threshold;

    zero_crossing_frequency_meter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    zcfm_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // random backpressure on the digit output
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // give up after too long without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("zero_crossing_frequency_meter test failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // offer one sample, with an optional idle gap first
    task automatic push_sample(input logic [SampleW-1:0] value);
        int gap;
        bit taken;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end while (!taken);
    endtask

    // stop sending and wait until every expected digit is out
    task automatic drain_block();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_THRESHOLD)
            cur_threshold = data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [CfgDataW-1:0] thr, input logic [CfgDataW-1:0] win);
        drain_block();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_WIN_LEN, win);
    endtask

    // a level strictly on one side of the threshold, or the threshold itself
    function automatic logic [SampleW-1:0] pick_level(input bit above);
        if (above && cur_threshold != 16'hFFFF)
            return SampleW'($urandom_range(int'(cur_threshold) + 1, 65535));
        if (!above && cur_threshold != 16'h0000)
            return SampleW'($urandom_range(0, int'(cur_threshold) - 1));
        return cur_threshold;
    endfunction

    // random samples, mostly a wave around the threshold with some noise
    task automatic run_segment(input int count);
        int  density;
        bit  above;
        logic [SampleW-1:0] value;
        density = $urandom_range(10, 100);
        above   = $urandom_range(0, 1);
        for (int i = 0; (i < count) && (random_sent < RANDOM_ITEMS); i++)
        begin
            if (random_sent < RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 25;
                rx_idle_pct = 53;
            end
            else if (random_sent < 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 53;
                rx_idle_pct = 25;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case ($urandom_range(0, 9))
                0: value = cur_threshold;
                1: value = SampleW'($urandom);
                2: value = {SampleW{1'($urandom_range(0, 1))}};
                default:
                begin
                    if ($urandom_range(0, 99) < density)
                        above = !above;
                    value = pick_level(above);
                end
            endcase
            push_sample(value);
            random_sent++;
        end
    endtask

    initial
    begin
        logic [CfgDataW-1:0] thr;
        logic [CfgDataW-1:0] win;
        int                  count;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_THRESHOLD;
        cfg_data      <= '0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        m_tready      <= 1'b0;
        stall_cycles  <= 0;
        tx_idle_pct   = 25;
        rx_idle_pct   = 53;
        random_sent   = 0;
        cur_threshold = ThresholdReset;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // low, full-scale rise, sample on the threshold, fall
        set_regs(ThresholdReset, 16'd4);
        push_sample(16'h0000);
        push_sample(16'hFFFF);
        push_sample(ThresholdReset);
        push_sample(16'h0000);

        // one-sample windows
        set_regs(ThresholdReset, 16'd1);
        push_sample(16'hFFFF);
        push_sample(16'h0000);

        // zero length acts as one
        set_regs(ThresholdReset, 16'd0);
        push_sample(16'd12345);

        // threshold at zero: equal samples do nothing
        set_regs(16'h0000, 16'd2);
        push_sample(16'h0000);
        push_sample(16'h0000);
        push_sample(16'h0000);
        push_sample(16'h0001);

        // threshold at full scale: nothing can be above it
        set_regs(16'hFFFF, 16'd2);
        push_sample(16'hFFFF);
        push_sample(16'hFFFE);

        // long window cut short by a lower length partway through
        set_regs(16'h8000, 16'd1024);
        for (int i = 0; i < 12; i++)
            push_sample(i[0] ? 16'hFFFF : 16'h0000);
        set_regs(16'h8000, 16'd4);
        push_sample(16'hFFFF);

        // random settings and samples
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       thr = 16'h0000;
                1:       thr = 16'hFFFF;
                default: thr = CfgDataW'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:       win = CfgDataW'($urandom_range(0, 1));
                1:       win = CfgDataW'($urandom_range(25, 120));
                2:       win = CfgDataW'($urandom_range(1025, 2047));
                default: win = CfgDataW'($urandom_range(2, 24));
            endcase
            if (win <= 24)
                count = (win < 1 ? 1 : int'(win)) * $urandom_range(1, 3) + $urandom_range(0, 3);
            else if (win <= 1024)
                count = int'(win) + $urandom_range(0, 10);
            else
                count = $urandom_range(5, 40);
            set_regs(thr, win);
            run_segment(count);
        end

        // window length with upper data bits set, then cut short
        set_regs(16'h8000, 16'hFFFF);
        for (int i = 0; i < 20; i++)
            push_sample(i[0] ? 16'hFFFF : 16'h0000);
        set_regs(16'h8000, 16'd4);
        push_sample(16'h0000);

        // wait out the last digits
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("zero_crossing_frequency_meter test passed");
        else
            $display("zero_crossing_frequency_meter test failed");
        $finish;
    end

endmodule
